// File: design/hdrb_pkg.sv
// ----------------------------------------------------------------------------
// hdrb_pkg: shared types and constants of the MAC data header builder
// Descriptor and configuration types, frame control codes, register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hdrb_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_PAN_ID          = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_LONG_ADDR   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OWN_SHORT_ADDR  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SEND_SOURCE_PAN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_IS_LONG  = 3'd4;

  localparam logic [1:0] KIND_BAD   = 2'd0;
  localparam logic [1:0] KIND_GROUP = 2'd1;
  localparam logic [1:0] KIND_SHORT = 2'd2;
  localparam logic [1:0] KIND_LONG  = 2'd3;

  localparam logic [7:0] FC0_DATA       = 8'h01;
  localparam logic [7:0] FC0_ACK_REQ    = 8'h20;
  localparam logic [7:0] FC0_PANID_COMP = 8'h40;
  localparam logic [7:0] FC1_BASE       = 8'h88;
  localparam logic [7:0] FC1_LONG_DST   = 8'h04;
  localparam logic [7:0] FC1_LONG_SRC   = 8'h40;
  localparam logic [7:0] BCAST_BYTE     = 8'hff;

  localparam logic [3:0] LEN_SHORT = 4'd2;
  localparam logic [3:0] LEN_LONG  = 4'd8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  seq;
    logic [63:0] dest;
  } desc_t;

  typedef struct packed {
    logic [15:0] pan_id;
    logic [63:0] own_long_address;
    logic [15:0] own_short_address;
    logic        send_source_pan;
    logic        source_is_long;
  } cfg_t;

endpackage

// File: design/hdrb_front.sv
// ----------------------------------------------------------------------------
// hdrb_front: request intake and classification
// Holds the configuration registers and the sequence counter, classifies
// each request and hands a descriptor to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdrb_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic                              q_full,
  input  logic                              group_destination,
  input  logic [3:0]                        dest_length,
  input  logic [63:0]                       dest_address,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hdrb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [hdrb_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              q_wr,
  output hdrb_pkg::desc_t                   q_desc,
  output hdrb_pkg::cfg_t                    cfg
);

  logic [7:0] seq;
  logic [1:0] kind;
  logic       cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign q_wr      = push && !q_full;

  always_comb begin
    if (group_destination) begin
      kind = hdrb_pkg::KIND_GROUP;
    end else if (dest_length == hdrb_pkg::LEN_SHORT) begin
      kind = hdrb_pkg::KIND_SHORT;
    end else if (dest_length == hdrb_pkg::LEN_LONG) begin
      kind = hdrb_pkg::KIND_LONG;
    end else begin
      kind = hdrb_pkg::KIND_BAD;
    end
  end

  assign q_desc.kind = kind;
  assign q_desc.seq  = seq;
  assign q_desc.dest = dest_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= 8'd0;
    end else if (q_wr && kind != hdrb_pkg::KIND_BAD) begin
      seq <= seq + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pan_id            <= 16'd0;
      cfg.own_long_address  <= 64'd0;
      cfg.own_short_address <= 16'd0;
      cfg.send_source_pan   <= 1'b0;
      cfg.source_is_long    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        hdrb_pkg::REG_PAN_ID:          cfg.pan_id <= cfg_data[15:0];
        hdrb_pkg::REG_OWN_LONG_ADDR:   cfg.own_long_address <= cfg_data;
        hdrb_pkg::REG_OWN_SHORT_ADDR:  cfg.own_short_address <= cfg_data[15:0];
        hdrb_pkg::REG_SEND_SOURCE_PAN: cfg.send_source_pan <= cfg_data[0];
        hdrb_pkg::REG_SOURCE_IS_LONG:  cfg.source_is_long <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/hdrb_queue.sv
// ----------------------------------------------------------------------------
// hdrb_queue: descriptor queue between intake and serializer
// Small register FIFO of frame descriptors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdrb_queue #(
  parameter int DEPTH = hdrb_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  hdrb_pkg::desc_t wr_desc,
  output logic            full,
  input  logic            rd,
  output logic            rd_valid,
  output hdrb_pkg::desc_t rd_desc
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hdrb_pkg::desc_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_rd;

  assign full     = (count == CNT_FULL);
  assign rd_valid = (count != '0);
  assign rd_desc  = entries[rd_ptr];
  assign do_rd    = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      entries[wr_ptr] <= wr_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({wr, do_rd})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/hdrb_back.sv
// ----------------------------------------------------------------------------
// hdrb_back: header serializer
// Walks the header fields of one descriptor, one byte per cycle, into an
// output register that holds while the consumer stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdrb_back (
  input  logic            clk,
  input  logic            rst,
  input  hdrb_pkg::cfg_t  cfg,
  input  logic            q_valid,
  input  hdrb_pkg::desc_t q_desc,
  output logic            q_rd,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      header_byte,
  output logic            last_byte,
  output logic            bad_length
);

  localparam logic [3:0] ST_FC0   = 4'd0;
  localparam logic [3:0] ST_FC1   = 4'd1;
  localparam logic [3:0] ST_SEQ   = 4'd2;
  localparam logic [3:0] ST_PAN0  = 4'd3;
  localparam logic [3:0] ST_PAN1  = 4'd4;
  localparam logic [3:0] ST_DST   = 4'd5;
  localparam logic [3:0] ST_SPAN0 = 4'd6;
  localparam logic [3:0] ST_SPAN1 = 4'd7;
  localparam logic [3:0] ST_SRC   = 4'd8;
  localparam logic [3:0] ST_BAD   = 4'd9;

  hdrb_pkg::desc_t desc;
  logic            busy;
  logic [3:0]      step;
  logic [3:0]      step_next;
  logic [2:0]      k;
  logic [2:0]      k_next;
  logic            out_valid;
  logic            advance;
  logic            load;
  logic [7:0]      byte_c;
  logic            last_c;
  logic [7:0]      fc0;
  logic [7:0]      fc1;
  logic [7:0]      dst_byte;
  logic [7:0]      src_byte;

  assign empty   = !out_valid;
  assign advance = busy && (!out_valid || pop);
  assign load    = q_valid && (!busy || (advance && last_c));
  assign q_rd    = load;

  assign fc0 = hdrb_pkg::FC0_DATA
             | ((desc.kind != hdrb_pkg::KIND_GROUP) ? hdrb_pkg::FC0_ACK_REQ : 8'h00)
             | (cfg.send_source_pan ? 8'h00 : hdrb_pkg::FC0_PANID_COMP);
  assign fc1 = hdrb_pkg::FC1_BASE
             | ((desc.kind == hdrb_pkg::KIND_LONG) ? hdrb_pkg::FC1_LONG_DST : 8'h00)
             | (cfg.source_is_long ? hdrb_pkg::FC1_LONG_SRC : 8'h00);

  assign dst_byte = (desc.kind == hdrb_pkg::KIND_GROUP) ? hdrb_pkg::BCAST_BYTE
                                                        : desc.dest[{k, 3'b000} +: 8];
  assign src_byte = cfg.source_is_long ? cfg.own_long_address[{k, 3'b000} +: 8]
                                       : cfg.own_short_address[{k[0], 3'b000} +: 8];

  always_comb begin
    byte_c    = 8'h00;
    last_c    = 1'b0;
    step_next = step;
    k_next    = k;
    case (step)
      ST_FC0: begin
        byte_c    = fc0;
        step_next = ST_FC1;
      end
      ST_FC1: begin
        byte_c    = fc1;
        step_next = ST_SEQ;
      end
      ST_SEQ: begin
        byte_c    = desc.seq;
        step_next = ST_PAN0;
      end
      ST_PAN0: begin
        byte_c    = cfg.pan_id[7:0];
        step_next = ST_PAN1;
      end
      ST_PAN1: begin
        byte_c    = cfg.pan_id[15:8];
        step_next = ST_DST;
        k_next    = (desc.kind == hdrb_pkg::KIND_LONG) ? 3'd7 : 3'd1;
      end
      ST_DST: begin
        byte_c = dst_byte;
        if (k == 3'd0) begin
          step_next = cfg.send_source_pan ? ST_SPAN0 : ST_SRC;
        end else begin
          k_next = k - 3'd1;
        end
      end
      ST_SPAN0: begin
        byte_c    = cfg.pan_id[7:0];
        step_next = ST_SPAN1;
      end
      ST_SPAN1: begin
        byte_c    = cfg.pan_id[15:8];
        step_next = ST_SRC;
      end
      ST_SRC: begin
        byte_c = src_byte;
        last_c = (k == (cfg.source_is_long ? 3'd7 : 3'd1));
        k_next = k + 3'd1;
      end
      ST_BAD: begin
        byte_c = 8'h00;
        last_c = 1'b1;
      end
      default: begin
        byte_c = 8'h00;
        last_c = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      step      <= ST_FC0;
      k         <= 3'd0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        step <= (q_desc.kind == hdrb_pkg::KIND_BAD) ? ST_BAD : ST_FC0;
        k    <= 3'd0;
      end else if (advance) begin
        busy <= !last_c;
        step <= step_next;
        k    <= k_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc <= q_desc;
    end
    if (advance) begin
      header_byte <= byte_c;
      last_byte   <= last_c;
      bad_length  <= (step == ST_BAD);
    end
  end

endmodule

// File: design/mac_data_header_builder_top.sv
// ----------------------------------------------------------------------------
// mac_data_header_builder_top: 802.15.4 data frame MAC header builder
// Turns frame requests into MAC header byte streams.
//
//   channel   direction  handshake            payload
//   request   in         push / full          group_destination, dest_length,
//                                             dest_address
//   header    out        empty / pop          header_byte, last_byte, bad_length
//   config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A header is 9 to 23 bytes, one byte per cycle from the serializer output
// register while pop keeps up; a bad-length request gives a single zero byte.
// Reset (rst, synchronous) empties the queue and output, zeroes the sequence
// number and loads the register reset values.
// A stalled pop holds the output byte; the descriptor queue keeps taking
// requests until it fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mac_data_header_builder_top #(
  parameter int QUEUE_DEPTH = hdrb_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic                              group_destination,
  input  logic [3:0]                        dest_length,
  input  logic [63:0]                       dest_address,
  output logic                              empty,
  input  logic                              pop,
  output logic [7:0]                        header_byte,
  output logic                              last_byte,
  output logic                              bad_length,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hdrb_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [hdrb_pkg::CFG_DATA_W-1:0]   cfg_data
);

  hdrb_pkg::desc_t wr_desc;
  hdrb_pkg::desc_t rd_desc;
  hdrb_pkg::cfg_t  cfg;
  logic            q_wr;
  logic            q_rd;
  logic            q_valid;

  hdrb_front u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .q_full            (full),
    .group_destination (group_destination),
    .dest_length       (dest_length),
    .dest_address      (dest_address),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .q_wr              (q_wr),
    .q_desc            (wr_desc),
    .cfg               (cfg)
  );

  hdrb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_desc  (wr_desc),
    .full     (full),
    .rd       (q_rd),
    .rd_valid (q_valid),
    .rd_desc  (rd_desc)
  );

  hdrb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_desc      (rd_desc),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .header_byte (header_byte),
    .last_byte   (last_byte),
    .bad_length  (bad_length)
  );

endmodule

// File: design/hdrb_checker.sv
// ----------------------------------------------------------------------------
// hdrb_checker: port-level checks of the header builder
// Watches the top level ports, checks the state after reset and flags output
// beats that break the header framing rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hdrb_checker (
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] header_byte,
  input logic       last_byte,
  input logic       bad_length
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queue or output not empty after reset");

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    !empty && bad_length |-> last_byte && header_byte == 8'h00)
    else $error("error beat is not a single zero byte");

  a_bad_after_last: assert property (@(posedge clk) disable iff (rst)
    !empty && pop && !last_byte ##1 !empty |-> !bad_length)
    else $error("error beat inside a header");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(header_byte) && $stable(last_byte))
    else $error("stalled output beat changed");

endmodule

bind mac_data_header_builder_top hdrb_checker u_hdrb_checker (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .header_byte (header_byte),
  .last_byte   (last_byte),
  .bad_length  (bad_length)
);
